// ===== rtl/core/sil_pkg.sv =====
// Shared types and codes for the sorted insertion list core.
// Holds request/result structs, command and status codes and the cell control struct.
// No dependencies.
package sil_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 5;

  typedef enum logic [1:0] {
    CMD_INSERT    = 2'd0,
    CMD_CLEAR     = 2'd1,
    CMD_READ_ASC  = 2'd2,
    CMD_READ_DESC = 2'd3
  } sil_cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } sil_status_e;

  typedef struct packed {
    logic [1:0]               cmd;
    logic signed [ValueW-1:0] new_value;
  } sil_req_t;

  typedef struct packed {
    logic signed [ValueW-1:0] entry_value;
    logic [CountW-1:0]        entry_count;
    logic                     last_of_run;
    logic [1:0]               status;
  } sil_result_t;

  // Per-cycle operation broadcast to every cell of the chain
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ROT_LEFT,
    CELL_ROT_RIGHT
  } sil_cell_op_e;

  typedef struct packed {
    sil_cell_op_e             op;
    logic signed [ValueW-1:0] new_value;
  } sil_cell_ctrl_t;

  // Per-cell position flags derived from the occupancy count
  typedef struct packed {
    logic valid;    // cell holds an entry
    logic is_end;   // first free cell
    logic is_tail;  // last occupied cell
  } sil_cell_pos_t;

endpackage

// ===== rtl/core/sil_cell.sv =====
// One cell of the sorted chain: holds a single entry and trades it with its neighbors.
// Depends on sil_pkg for the control and position structs.
module sil_cell (
  input  logic                             clk_i,
  input  sil_pkg::sil_cell_ctrl_t          ctrl_i,
  input  sil_pkg::sil_cell_pos_t           pos_i,
  input  logic                             left_take_i,
  input  logic signed [sil_pkg::ValueW-1:0] left_value_i,
  input  logic signed [sil_pkg::ValueW-1:0] right_value_i,
  input  logic signed [sil_pkg::ValueW-1:0] wrap_value_i,
  output logic                             take_o,
  output logic signed [sil_pkg::ValueW-1:0] value_o
);
  import sil_pkg::*;

  logic signed [ValueW-1:0] value_q, value_d;

  // Claim the new value: every entry not below it moves one place up
  assign take_o = pos_i.valid ? (value_q >= ctrl_i.new_value) : pos_i.is_end;

  // Select the next entry for this cell
  always_comb begin
    value_d = value_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        if (left_take_i) begin
          value_d = left_value_i;
        end else if (take_o) begin
          value_d = ctrl_i.new_value;
        end
      end
      CELL_ROT_LEFT: begin
        value_d = pos_i.is_tail ? wrap_value_i : right_value_i;
      end
      CELL_ROT_RIGHT: begin
        value_d = left_value_i;
      end
      default: begin
        value_d = value_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

// ===== rtl/core/sorted_insertion_list_core.sv =====
// Top level of the sorted insertion list: sequencer, occupancy count and the cell chain.
// Depends on sil_pkg and sil_cell.
//
// Usage:
//   A request (cmd, new_value) is taken at a rising edge where start is high and busy is
//   low. Results come out on result_o for exactly one cycle each, marked by valid_o; the
//   receiver cannot stall them and must take every one.
//   Insert, clear and a read of an empty list give one result, registered in the cycle
//   after the request is taken; busy stays low, so a new request may follow every cycle.
//   Insert compares the new value against all cells at once and moves every entry not
//   below it up one place in the same cycle. An insert into a full list is dropped with
//   status full.
//   A read of n entries rotates the chain one place per cycle (left for ascending,
//   right for descending) and streams one entry per cycle; busy is high while the chain
//   rotates, and after the n-th rotation the chain is back in order. The final result
//   of each request has last_of_run set.
//   Reset clears the occupancy count and the sequencer; cell contents stay undefined
//   and are never read before they are written.
module sorted_insertion_list_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  sil_pkg::sil_req_t    req_i,
  output logic                 busy,
  output logic                 valid_o,
  output sil_pkg::sil_result_t result_o
);
  import sil_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] read_idx_q;
  logic            desc_q;
  logic            out_valid_q;
  sil_result_t     out_q;

  logic                     accept;
  logic                     full;
  logic                     last_read;
  logic [ValueW-1:0]        tail_value;
  logic [CAPACITY-1:0]      take;
  logic signed [ValueW-1:0] cell_val [CAPACITY];
  sil_cell_ctrl_t           cell_ctrl;
  logic [CountW-1:0]        count_out;
  logic [31:0]              count_wide;

  assign busy      = (state_q == ST_READ);
  assign accept    = start && !busy;
  assign full      = (count_q == CntW'(CAPACITY));
  assign last_read = ((read_idx_q + 1'b1) == count_q);

  // Mask the count to the result field width
  assign count_wide = 32'(count_q);
  assign count_out  = count_wide[CountW-1:0];

  // Pick the last occupied cell for descending reads
  always_comb begin
    tail_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (count_q == CntW'(i + 1)) begin
        tail_value = tail_value | cell_val[i];
      end
    end
  end

  // Drive the chain operation
  always_comb begin
    cell_ctrl.new_value = req_i.new_value;
    cell_ctrl.op        = CELL_HOLD;
    if (busy) begin
      cell_ctrl.op = desc_q ? CELL_ROT_RIGHT : CELL_ROT_LEFT;
    end else if (accept && (req_i.cmd == CMD_INSERT) && !full) begin
      cell_ctrl.op = CELL_INSERT;
    end
  end

  // Build the chain of cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    sil_cell_pos_t            pos;
    logic                     left_take;
    logic signed [ValueW-1:0] left_value;
    logic signed [ValueW-1:0] right_value;

    assign pos.valid   = (count_q > CntW'(g));
    assign pos.is_end  = (count_q == CntW'(g));
    assign pos.is_tail = (count_q == CntW'(g + 1));

    if (g == 0) begin : g_head
      assign left_take  = 1'b0;
      assign left_value = tail_value;
    end else begin : g_body
      assign left_take  = take[g-1];
      assign left_value = cell_val[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_value = cell_val[0];
    end else begin : g_inner
      assign right_value = cell_val[g+1];
    end

    sil_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (cell_ctrl),
      .pos_i        (pos),
      .left_take_i  (left_take),
      .left_value_i (left_value),
      .right_value_i(right_value),
      .wrap_value_i (cell_val[0]),
      .take_o       (take[g]),
      .value_o      (cell_val[g])
    );
  end

  // Sequence requests, hold the count and register the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      read_idx_q  <= '0;
      desc_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            out_q.entry_value <= '0;
            out_q.last_of_run <= 1'b1;
            case (req_i.cmd)
              CMD_INSERT: begin
                out_valid_q <= 1'b1;
                if (full) begin
                  out_q.status      <= STATUS_FULL;
                  out_q.entry_count <= count_out;
                end else begin
                  count_q           <= count_q + 1'b1;
                  out_q.status      <= STATUS_OK;
                  out_q.entry_count <= CountW'(32'(count_q) + 32'd1);
                end
              end
              CMD_CLEAR: begin
                out_valid_q       <= 1'b1;
                count_q           <= '0;
                out_q.status      <= STATUS_OK;
                out_q.entry_count <= '0;
              end
              default: begin
                if (count_q == '0) begin
                  out_valid_q       <= 1'b1;
                  out_q.status      <= STATUS_EMPTY;
                  out_q.entry_count <= '0;
                end else begin
                  state_q    <= ST_READ;
                  read_idx_q <= '0;
                  desc_q     <= (req_i.cmd == CMD_READ_DESC);
                end
              end
            endcase
          end
        end
        ST_READ: begin
          // Emit one entry and advance the rotation
          out_valid_q       <= 1'b1;
          out_q.entry_value <= desc_q ? tail_value : cell_val[0];
          out_q.entry_count <= count_out;
          out_q.last_of_run <= last_read;
          out_q.status      <= STATUS_OK;
          read_idx_q        <= read_idx_q + 1'b1;
          if (last_read) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign valid_o  = out_valid_q;
  assign result_o = out_q;

endmodule

// ===== verif/sorted_insertion_list_core_tb.sv =====
// Self-checking testbench for sorted_insertion_list_core: directed and random request traffic.
// Predicts every result from its own copy of the sorted store and checks each strobed result.
// Depends on sil_pkg and the sorted_insertion_list_core RTL.
module sorted_insertion_list_core_tb;
  import sil_pkg::*;

  localparam int unsigned Capacity       = 16;
  localparam int unsigned RandomRequests = 500;
  localparam int unsigned CycleLimit     = 200000;
  localparam int unsigned MaxReports     = 10;
  localparam int unsigned SettleCycles   = Capacity + 4;

  localparam logic [ValueW-1:0] MinValue = 32'h8000_0000;
  localparam logic [ValueW-1:0] MaxValue = 32'h7fff_ffff;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        valid_o;
  sil_req_t    req_i;
  sil_result_t result_o;

  // Predicted store and the results still to come
  logic signed [ValueW-1:0] sorted_copy [Capacity];
  int unsigned              held_count   = 0;
  sil_result_t              pending_results [$];

  int unsigned error_count  = 0;
  int unsigned report_count = 0;
  int unsigned cycle_count  = 0;
  int unsigned burst_left   = 0;

  sorted_insertion_list_core #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i,
    .rst_ni,
    .start,
    .req_i,
    .busy,
    .valid_o,
    .result_o
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Update the store copy for one accepted request and queue the results it causes
  function automatic void predict_list_results(sil_req_t req);
    sil_result_t              res;
    logic signed [ValueW-1:0] value;
    int unsigned              pos;
    int unsigned              idx;
    res = '0;
    res.last_of_run = 1'b1;
    value = $signed(req.new_value);
    case (req.cmd)
      CMD_INSERT: begin
        if (held_count >= Capacity) begin
          res.entry_count = CountW'(Capacity);
          res.status      = STATUS_FULL;
        end else begin
          // place ahead of equal entries: stop at the first entry not below the value
          pos = 0;
          while (pos < held_count && sorted_copy[pos] < value) pos++;
          for (idx = held_count; idx > pos; idx--) sorted_copy[idx] = sorted_copy[idx - 1];
          sorted_copy[pos] = value;
          held_count++;
          res.entry_count = CountW'(held_count);
          res.status      = STATUS_OK;
        end
        pending_results.push_back(res);
      end
      CMD_CLEAR: begin
        held_count = 0;
        res.status = STATUS_OK;
        pending_results.push_back(res);
      end
      default: begin
        if (held_count == 0) begin
          res.status = STATUS_EMPTY;
          pending_results.push_back(res);
        end else begin
          for (idx = 0; idx < held_count; idx++) begin
            res.entry_value = (req.cmd == CMD_READ_ASC) ? sorted_copy[idx]
                                                        : sorted_copy[held_count - 1 - idx];
            res.entry_count = CountW'(held_count);
            res.last_of_run = (idx == held_count - 1);
            res.status      = STATUS_OK;
            pending_results.push_back(res);
          end
        end
      end
    endcase
  endfunction

  // Idle between bursts of random length
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Present one request and hold it until the block takes it
  task automatic send_request(sil_cmd_e cmd, logic [ValueW-1:0] value);
    sil_req_t req;
    req.cmd       = cmd;
    req.new_value = value;
    start <= 1'b1;
    req_i <= req;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_list_results(req);
    pace_sender();
  endtask

  // Hold off new requests until every predicted result has come back
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic test_empty_list();
    send_request(CMD_READ_ASC, $urandom);
    send_request(CMD_READ_DESC, $urandom);
    send_request(CMD_CLEAR, $urandom);
    drain_results();
  endtask

  // Extremes of the value range, with duplicates of both ends
  task automatic test_value_extremes();
    send_request(CMD_INSERT, MinValue);
    send_request(CMD_INSERT, MaxValue);
    send_request(CMD_INSERT, '0);
    send_request(CMD_INSERT, '1);
    send_request(CMD_INSERT, MaxValue);
    send_request(CMD_INSERT, MinValue);
    send_request(CMD_READ_ASC, $urandom);
    send_request(CMD_READ_DESC, $urandom);
    drain_results();
  endtask

  // Fill to capacity, overflow once, read back and empty
  task automatic test_full_list();
    while (held_count < Capacity) send_request(CMD_INSERT, $urandom);
    send_request(CMD_INSERT, $urandom);
    send_request(CMD_READ_DESC, $urandom);
    send_request(CMD_CLEAR, $urandom);
    drain_results();
  endtask

  task automatic test_random_traffic();
    sil_cmd_e          cmd;
    logic [ValueW-1:0] value;
    int unsigned       pick;
    for (int unsigned n = 0; n < RandomRequests; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)      cmd = CMD_INSERT;
      else if (pick < 63) cmd = CMD_CLEAR;
      else if (pick < 82) cmd = CMD_READ_ASC;
      else                cmd = CMD_READ_DESC;
      // mix full-range values, near-zero values that collide, and the range ends
      case ($urandom_range(0, 9))
        0:       value = ($urandom_range(0, 1) == 0) ? MinValue : MaxValue;
        1, 2, 3: value = int'($urandom_range(0, 16)) - 8;
        default: value = $urandom;
      endcase
      send_request(cmd, value);
      if (n % 125 == 124) drain_results();
    end
    drain_results();
  endtask

  // Check each strobed result against the oldest prediction
  always @(posedge clk_i) begin
    sil_result_t predicted;
    if (rst_ni && valid_o) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (report_count < MaxReports) begin
          report_count++;
          $display("unexpected result: value %0d count %0d last %0b status %0d",
                   result_o.entry_value, result_o.entry_count, result_o.last_of_run,
                   result_o.status);
        end
      end else begin
        predicted = pending_results.pop_front();
        if (result_o.entry_value !== predicted.entry_value ||
            result_o.entry_count !== predicted.entry_count ||
            result_o.last_of_run !== predicted.last_of_run ||
            result_o.status !== predicted.status) begin
          error_count++;
          if (report_count < MaxReports) begin
            report_count++;
            $display("mismatch: expected value %0d count %0d last %0b status %0d",
                     predicted.entry_value, predicted.entry_count, predicted.last_of_run,
                     predicted.status);
            $display("          actual   value %0d count %0d last %0b status %0d",
                     result_o.entry_value, result_o.entry_count, result_o.last_of_run,
                     result_o.status);
          end
        end
      end
    end
  end

  // Abort a run that exceeds the cycle limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("sorted_insertion_list_core regression: fail");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_list();
    test_value_extremes();
    test_full_list();
    test_random_traffic();

    error_count += pending_results.size();
    if (error_count == 0) begin
      $display("sorted_insertion_list_core regression: pass");
    end else begin
      $display("sorted_insertion_list_core regression: fail");
    end
    $finish;
  end

endmodule
